// ===== rtl/core/sdps_pkg.sv =====
// Shared types and constants of the seam darkening pixel shader.
`default_nettype none

package sdps_pkg;

   localparam int unsigned PIXEL_BITS   = 8;
   localparam int unsigned COLUMN_WIDTH = 12;
   localparam int unsigned JOIN_BITS    = 13;
   localparam int unsigned JOIN_SLOTS   = 5;
   localparam int unsigned BW_BITS      = 8;
   localparam int unsigned WEIGHT_BITS  = 9;
   localparam int unsigned CSR_IDX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 13;

   // Quotient of the weight ramp never exceeds 256, so nine bits suffice.
   localparam int unsigned QUO_BITS    = 9;
   localparam int unsigned NUM_BITS    = BW_BITS + QUO_BITS;
   localparam int unsigned DIV_STAGES  = 3;
   localparam int unsigned DIV_STEPS   = QUO_BITS / DIV_STAGES;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 9'd256;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BLUR_WIDTH    = 3'd0,
      CSR_EDGE_WEIGHT   = 3'd1,
      CSR_MIDDLE_WEIGHT = 3'd2,
      CSR_JOIN_FIRST    = 3'd3,
      CSR_JOIN_SECOND   = 3'd4,
      CSR_JOIN_THIRD    = 3'd5,
      CSR_JOIN_FOURTH   = 3'd6,
      CSR_JOIN_FIFTH    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [COLUMN_WIDTH-1:0] column;
      logic [PIXEL_BITS-1:0]   blue_in;
      logic [PIXEL_BITS-1:0]   green_in;
      logic [PIXEL_BITS-1:0]   red_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] blue_out;
      logic [PIXEL_BITS-1:0] green_out;
      logic [PIXEL_BITS-1:0] red_out;
   } rsp_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] blue;
      logic [PIXEL_BITS-1:0] green;
      logic [PIXEL_BITS-1:0] red;
   } pixel_type;

   // Side information that rides along with a word through the divider.
   typedef struct packed {
      logic      hit;
      logic      neg;
      pixel_type pix;
   } div_tag_type;

endpackage

`default_nettype wire

// ===== rtl/core/sdps_div.sv =====
// Pipelined restoring divider for the weight ramp, three quotient bits per stage.
`default_nettype none

module sdps_div
   import sdps_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [NUM_BITS-1:0] in_num,
   input  wire logic [BW_BITS-1:0]  divisor,
   input  wire div_tag_type         in_tag,
   output logic                     out_valid,
   output logic [QUO_BITS-1:0]      out_quo,
   output div_tag_type              out_tag
);

   typedef struct packed {
      logic [BW_BITS-1:0]  rem;
      logic [QUO_BITS-1:0] low;
      logic [QUO_BITS-1:0] quo;
      div_tag_type         tag;
   } div_state_type;

   logic          vld_ff [DIV_STAGES+1];
   div_state_type st_ff  [DIV_STAGES+1];

   // The upper numerator bits are already below the divisor, so the
   // partial remainder starts with them.
   assign vld_ff[0] = in_valid;
   assign st_ff[0]  = '{rem: in_num[NUM_BITS-1:QUO_BITS],
                        low: in_num[QUO_BITS-1:0],
                        quo: '0,
                        tag: in_tag};

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      div_state_type st_in;

      always_comb begin
         logic [BW_BITS:0] trial;
         st_in = st_ff[g];
         for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {st_in.rem, st_in.low[QUO_BITS-1]};
            st_in.low = {st_in.low[QUO_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               trial = trial - {1'b0, divisor};
               st_in.quo = {st_in.quo[QUO_BITS-2:0], 1'b1};
            end else begin
               st_in.quo = {st_in.quo[QUO_BITS-2:0], 1'b0};
            end
            st_in.rem = trial[BW_BITS-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else begin
            vld_ff[g+1] <= vld_ff[g];
         end
         st_ff[g+1] <= st_in;
      end
   end

   assign out_valid = vld_ff[DIV_STAGES];
   assign out_quo   = st_ff[DIV_STAGES].quo;
   assign out_tag   = st_ff[DIV_STAGES].tag;

endmodule

`default_nettype wire

// ===== rtl/core/seam_darkening_pixel_shader.sv =====
// Top level of the seam darkening pixel shader: seam match, weight ramp and scaling.
`default_nettype none

// Darkens pixels of a stitched panorama near up to SEAM_COUNT seam columns.
// Input: a word on req_data (column and BGR pixel) is taken at every rising
// edge where start is high; busy stays low, so a new pixel may enter every
// cycle. Output: rsp_valid pulses for one cycle with the darkened pixel on
// rsp_data; words leave in the order they entered, one per word taken.
// The pipeline registers, in order, are seam match, ramp product, three
// divider stages (three quotient bits each against the band width), weight
// sum and channel scaling. Throughput is one pixel per clock; the pipeline
// has no stall path since the receiver cannot hold results off.
// Settings are written through csr_we/csr_index/csr_wdata, one register per
// write, and must only change while no pixel is in flight.
// Synchronous reset empties the pipeline and loads the band width and both
// weights with zero and every join column with 8191, which turns all seams
// off.
module seam_darkening_pixel_shader
   import sdps_pkg::*;
#(
   parameter int unsigned SEAM_COUNT  = 5,
   parameter int unsigned COLUMN_BITS = 12
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int unsigned LIMIT_INT = 1 << COLUMN_BITS;
   localparam logic [JOIN_BITS:0] LIMIT = LIMIT_INT[JOIN_BITS:0];

   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [BW_BITS-1:0] t;
      pixel_type          pix;
   } match_type;

   typedef struct packed {
      logic                valid;
      logic [NUM_BITS-1:0] prod;
      div_tag_type         tag;
   } ramp_type;

   typedef struct packed {
      logic                   valid;
      logic                   hit;
      logic [WEIGHT_BITS-1:0] w;
      pixel_type              pix;
   } weight_type;

   logic [BW_BITS-1:0]     band_width_ff;
   logic [WEIGHT_BITS-1:0] edge_weight_ff;
   logic [WEIGHT_BITS-1:0] middle_weight_ff;
   logic [JOIN_BITS-1:0]   joins_ff [JOIN_SLOTS];

   match_type  s1_in, s1_ff;
   ramp_type   s2_in, s2_ff;
   weight_type s6_in, s6_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_in, rsp_ff;

   logic                   div_valid;
   logic [QUO_BITS-1:0]    div_quo;
   div_tag_type            div_tag;
   logic [WEIGHT_BITS-1:0] edge_c;
   logic [WEIGHT_BITS-1:0] middle_c;

   assign busy = 1'b0;

   // ------------------------------------------------------------------
   // Settings
   always_ff @(posedge clock) begin
      if (reset) begin
         band_width_ff    <= '0;
         edge_weight_ff   <= '0;
         middle_weight_ff <= '0;
         for (int i = 0; i < JOIN_SLOTS; i++) begin
            joins_ff[i] <= '1;
         end
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BLUR_WIDTH:    band_width_ff    <= csr_wdata[BW_BITS-1:0];
            CSR_EDGE_WEIGHT:   edge_weight_ff   <= csr_wdata[WEIGHT_BITS-1:0];
            CSR_MIDDLE_WEIGHT: middle_weight_ff <= csr_wdata[WEIGHT_BITS-1:0];
            CSR_JOIN_FIRST:    joins_ff[0]      <= csr_wdata[JOIN_BITS-1:0];
            CSR_JOIN_SECOND:   joins_ff[1]      <= csr_wdata[JOIN_BITS-1:0];
            CSR_JOIN_THIRD:    joins_ff[2]      <= csr_wdata[JOIN_BITS-1:0];
            CSR_JOIN_FOURTH:   joins_ff[3]      <= csr_wdata[JOIN_BITS-1:0];
            CSR_JOIN_FIFTH:    joins_ff[4]      <= csr_wdata[JOIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Weights above one are full black.
   assign edge_c   = (edge_weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : edge_weight_ff;
   assign middle_c = (middle_weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : middle_weight_ff;

   // ------------------------------------------------------------------
   // Stage 1: find the last seam whose window holds the column.
   always_comb begin
      logic                 enable;
      logic [JOIN_BITS-1:0] col;
      logic [JOIN_BITS-1:0] gap;
      logic                 hit;
      logic [BW_BITS-1:0]   t;
      col    = JOIN_BITS'(req_data.column);
      enable = (band_width_ff != '0) &&
               ((edge_weight_ff != '0) || (middle_weight_ff != '0)) &&
               ((JOIN_BITS+1)'(req_data.column) < LIMIT);
      hit    = 1'b0;
      t      = '0;
      for (int i = 0; i < SEAM_COUNT; i++) begin
         gap = (col >= joins_ff[i]) ? (col - joins_ff[i]) : (joins_ff[i] - col);
         if (({1'b0, joins_ff[i]} < LIMIT) &&
             (gap <= JOIN_BITS'(band_width_ff))) begin
            hit = 1'b1;
            t   = band_width_ff - gap[BW_BITS-1:0];
         end
      end
      s1_in.valid     = start && !busy;
      s1_in.hit       = hit && enable;
      s1_in.t         = t;
      s1_in.pix.blue  = req_data.blue_in;
      s1_in.pix.green = req_data.green_in;
      s1_in.pix.red   = req_data.red_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: magnitude of (middle - edge) times (band width - d).
   always_comb begin
      logic                   neg;
      logic [WEIGHT_BITS-1:0] mag;
      neg = middle_c < edge_c;
      mag = neg ? (edge_c - middle_c) : (middle_c - edge_c);
      s2_in.valid   = s1_ff.valid;
      s2_in.prod    = NUM_BITS'(mag) * NUM_BITS'(s1_ff.t);
      s2_in.tag.hit = s1_ff.hit;
      s2_in.tag.neg = neg;
      s2_in.tag.pix = s1_ff.pix;
   end

   // Stages 3 to 5: quotient by the band width, truncated toward zero.
   sdps_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_ff.valid),
      .in_num    (s2_ff.prod),
      .divisor   (band_width_ff),
      .in_tag    (s2_ff.tag),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // Stage 6: black weight.
   always_comb begin
      s6_in.valid = div_valid;
      s6_in.hit   = div_tag.hit;
      s6_in.w     = div_tag.neg ? (edge_c - div_quo) : (edge_c + div_quo);
      s6_in.pix   = div_tag.pix;
   end

   // Stage 7: scale each channel by the remaining light.
   always_comb begin
      logic [WEIGHT_BITS-1:0] scale;
      logic [NUM_BITS-1:0]    pb, pg, pr;
      if (!s6_ff.hit) begin
         scale = WEIGHT_ONE;
      end else if (s6_ff.w > WEIGHT_ONE) begin
         scale = '0;
      end else begin
         scale = WEIGHT_ONE - s6_ff.w;
      end
      pb = NUM_BITS'(s6_ff.pix.blue)  * NUM_BITS'(scale);
      pg = NUM_BITS'(s6_ff.pix.green) * NUM_BITS'(scale);
      pr = NUM_BITS'(s6_ff.pix.red)   * NUM_BITS'(scale);
      rsp_in.blue_out  = pb[2*PIXEL_BITS-1:PIXEL_BITS];
      rsp_in.green_out = pg[2*PIXEL_BITS-1:PIXEL_BITS];
      rsp_in.red_out   = pr[2*PIXEL_BITS-1:PIXEL_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s6_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff.valid  <= s1_in.valid;
         s2_ff.valid  <= s2_in.valid;
         s6_ff.valid  <= s6_in.valid;
         rsp_valid_ff <= s6_ff.valid;
      end
      s1_ff.hit  <= s1_in.hit;
      s1_ff.t    <= s1_in.t;
      s1_ff.pix  <= s1_in.pix;
      s2_ff.prod <= s2_in.prod;
      s2_ff.tag  <= s2_in.tag;
      s6_ff.hit  <= s6_in.hit;
      s6_ff.w    <= s6_in.w;
      s6_ff.pix  <= s6_in.pix;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Every word taken comes out as a result.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 rsp_valid)
      else $error("accepted word did not leave after seven cycles");

   // No result appears without a matching word taken before it.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 7))
      else $error("result without a matching input word");

   // Darkening never brightens any channel.
   a_never_brighter : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.blue_out  <= $past(req_data.blue_in, 7)) &&
                    (rsp_data.green_out <= $past(req_data.green_in, 7)) &&
                    (rsp_data.red_out   <= $past(req_data.red_in, 7)))
      else $error("output channel brighter than its input");

endmodule

`default_nettype wire
